>>> rtl/core/limit_order_book_matcher_assert.svh
// Assertion macros shared by the order book RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante
`define LOBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check cons in the cycle after ante
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LOBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

  localparam int ID_W     = 64;
  localparam int QTY_W    = 32;
  localparam int PRICE_W  = 8;
  localparam int STATUS_W = 3;
  localparam int FILLS_W  = 9;
  localparam int SEQ_W    = 64;

  // Tick levels per side; ticks at or above this saturate to the top level
  localparam int PRICE_LEVELS = 256;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_RESTED    = 3'd0,
    STAT_FILLED    = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_UNKNOWN   = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_DUP       = 3'd5,
    STAT_ZERO      = 3'd6
  } lobm_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } lobm_state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_KILL,
    OP_TRADE
  } lobm_op_t;

  // Order being worked, seen by every cell
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               side;
    logic [PRICE_W-1:0] price;
  } lobm_query_t;

  // Write to one cell of the row
  typedef struct packed {
    lobm_op_t           op;
    logic [ID_W-1:0]    id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [SEQ_W-1:0]   seq;
  } lobm_upd_t;

  // Scan result handed from cell to cell
  typedef struct packed {
    logic               hit;
    logic               free_found;
    logic               best_found;
    logic [PRICE_W-1:0] best_price;
    logic [SEQ_W-1:0]   best_seq;
    logic [QTY_W-1:0]   best_qty;
  } lobm_cand_t;

endpackage
`default_nettype wire

>>> rtl/core/lobm_if.sv
`default_nettype none
interface lobm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [lobm_pkg::ID_W-1:0]    order_id;
  logic                         side;
  logic [lobm_pkg::PRICE_W-1:0] price_tick;
  logic [lobm_pkg::QTY_W-1:0]   quantity;

  modport source (output valid, cmd, order_id, side, price_tick, quantity, input ready);
  modport sink   (input valid, cmd, order_id, side, price_tick, quantity, output ready);
endinterface

interface lobm_out_if;
  logic                          valid;
  logic                          ready;
  logic [lobm_pkg::STATUS_W-1:0] status;
  logic [lobm_pkg::QTY_W-1:0]    filled_quantity;
  logic [lobm_pkg::QTY_W-1:0]    resting_quantity;
  logic [lobm_pkg::FILLS_W-1:0]  fill_count;

  modport source (output valid, status, filled_quantity, resting_quantity, fill_count,
                  input ready);
  modport sink   (input valid, status, filled_quantity, resting_quantity, fill_count,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/limit_order_book_matcher.sv
`default_nettype none
// Limit order book with price-time priority. Resting orders live in a row of
// MAX_ORDERS cells; a scan word runs along the row one cell per cycle and
// gathers the id match, the first free cell and the best crossing order.
// A cancel or a rejected add takes one scan; an add takes one scan for each
// resting order it trades against, plus a last scan that finds nothing left
// to cross unless the add fills completely. The length of the cell row sets
// the length of a scan. One item is worked at a time, and the result register
// lets the next word in while a result waits. Cell valid bits clear at reset,
// so the book is usable straight after reset.
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lobm_in_if.sink    in_ch,
  lobm_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_ORDERS);

  lobm_pkg::lobm_query_t q;
  lobm_pkg::lobm_upd_t   upd;
  logic [IDX_W-1:0]      upd_idx;
  lobm_pkg::lobm_cand_t  cand_w [MAX_ORDERS];
  logic [IDX_W-1:0]      hit_w  [MAX_ORDERS];
  logic [IDX_W-1:0]      free_w [MAX_ORDERS];
  logic [IDX_W-1:0]      best_w [MAX_ORDERS];

  // Sequence the commands and own the result word
  lobm_ctrl #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .q        (q),
    .upd      (upd),
    .upd_idx  (upd_idx),
    .cand     (cand_w[MAX_ORDERS-1]),
    .hit_idx  (hit_w[MAX_ORDERS-1]),
    .free_idx (free_w[MAX_ORDERS-1]),
    .best_idx (best_w[MAX_ORDERS-1])
  );

  // Row of order cells, scan word passed left to right
  for (genvar gi = 0; gi < MAX_ORDERS; gi++) begin : g_cell
    lobm_pkg::lobm_cand_t c_in;
    logic [IDX_W-1:0]     h_in;
    logic [IDX_W-1:0]     f_in;
    logic [IDX_W-1:0]     b_in;

    if (gi == 0) begin : g_first
      assign c_in = '0;
      assign h_in = '0;
      assign f_in = '0;
      assign b_in = '0;
    end else begin : g_rest
      assign c_in = cand_w[gi-1];
      assign h_in = hit_w[gi-1];
      assign f_in = free_w[gi-1];
      assign b_in = best_w[gi-1];
    end

    lobm_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (gi)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .q            (q),
      .upd          (upd),
      .upd_idx      (upd_idx),
      .cand_in      (c_in),
      .hit_idx_in   (h_in),
      .free_idx_in  (f_in),
      .best_idx_in  (b_in),
      .cand_out     (cand_w[gi]),
      .hit_idx_out  (hit_w[gi]),
      .free_idx_out (free_w[gi]),
      .best_idx_out (best_w[gi])
    );
  end

endmodule
`default_nettype wire

>>> rtl/core/lobm_cell.sv
`default_nettype none
`include "limit_order_book_matcher_assert.svh"
module lobm_cell #(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lobm_pkg::lobm_query_t q,
  input  wire lobm_pkg::lobm_upd_t  upd,
  input  wire logic [IDX_W-1:0]     upd_idx,
  input  wire lobm_pkg::lobm_cand_t cand_in,
  input  wire logic [IDX_W-1:0]     hit_idx_in,
  input  wire logic [IDX_W-1:0]     free_idx_in,
  input  wire logic [IDX_W-1:0]     best_idx_in,
  output lobm_pkg::lobm_cand_t      cand_out,
  output logic [IDX_W-1:0]          hit_idx_out,
  output logic [IDX_W-1:0]          free_idx_out,
  output logic [IDX_W-1:0]          best_idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                                valid_r, valid_nxt;
  logic [lobm_pkg::ID_W-1:0]           id_r, id_nxt;
  logic                                side_r, side_nxt;
  logic [lobm_pkg::PRICE_W-1:0]        price_r, price_nxt;
  logic [lobm_pkg::QTY_W-1:0]          qty_r, qty_nxt;
  logic [lobm_pkg::SEQ_W-1:0]          seq_r, seq_nxt;
  lobm_pkg::lobm_cand_t                cand_r, cand_nxt;
  logic [IDX_W-1:0]                    hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]                    free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]                    best_idx_r, best_idx_nxt;
  logic                                sel;
  logic                                hit_here;
  logic                                crosses;
  logic                                eligible;
  logic                                price_better;
  logic                                better;

  assign sel = (upd_idx == MY_IDX);

  // Apply writes aimed at this cell
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    side_nxt  = side_r;
    price_nxt = price_r;
    qty_nxt   = qty_r;
    seq_nxt   = seq_r;
    if (sel) begin
      case (upd.op)
        lobm_pkg::OP_INSERT: begin
          valid_nxt = 1'b1;
          id_nxt    = upd.id;
          side_nxt  = upd.side;
          price_nxt = upd.price;
          qty_nxt   = upd.qty;
          seq_nxt   = upd.seq;
        end
        lobm_pkg::OP_KILL: begin
          valid_nxt = 1'b0;
        end
        lobm_pkg::OP_TRADE: begin
          qty_nxt   = qty_r - upd.qty;
          valid_nxt = (qty_r != upd.qty);
        end
        default: begin
        end
      endcase
    end
  end

  // Merge this cell into the scan word from the left neighbour
  always_comb begin
    hit_here     = valid_r && (id_r == q.id);
    crosses      = (q.side == lobm_pkg::SIDE_BUY) ? (price_r <= q.price) : (price_r >= q.price);
    eligible     = valid_r && (side_r != q.side) && crosses;
    price_better = (q.side == lobm_pkg::SIDE_BUY) ? (price_r < cand_in.best_price)
                                                  : (price_r > cand_in.best_price);
    better       = !cand_in.best_found || price_better ||
                   ((price_r == cand_in.best_price) && (seq_r < cand_in.best_seq));
    cand_nxt     = cand_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    best_idx_nxt = best_idx_in;
    if (hit_here) begin
      cand_nxt.hit = 1'b1;
      hit_idx_nxt  = MY_IDX;
    end
    if (!valid_r && !cand_in.free_found) begin
      cand_nxt.free_found = 1'b1;
      free_idx_nxt        = MY_IDX;
    end
    if (eligible && better) begin
      cand_nxt.best_found = 1'b1;
      cand_nxt.best_price = price_r;
      cand_nxt.best_seq   = seq_r;
      cand_nxt.best_qty   = qty_r;
      best_idx_nxt        = MY_IDX;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
    end
  end

  // Order payload and scan indices
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    side_r     <= side_nxt;
    price_r    <= price_nxt;
    qty_r      <= qty_nxt;
    seq_r      <= seq_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign cand_out     = cand_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;
  assign best_idx_out = best_idx_r;

  `LOBM_ASSERT_IMPL(a_cell_live_target, clk, rst_n, sel && (upd.op == lobm_pkg::OP_KILL || upd.op == lobm_pkg::OP_TRADE), valid_r, "cancel or trade aimed at an empty cell")
  `LOBM_ASSERT_IMPL(a_cell_free_target, clk, rst_n, sel && upd.op == lobm_pkg::OP_INSERT, !valid_r, "insert over a resting order")

endmodule
`default_nettype wire

>>> rtl/core/lobm_ctrl.sv
`default_nettype none
`include "limit_order_book_matcher_assert.svh"
module lobm_ctrl #(
  parameter int MAX_ORDERS = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lobm_in_if.sink                                in_ch,
  lobm_out_if.source                             out_ch,
  output lobm_pkg::lobm_query_t                  q,
  output lobm_pkg::lobm_upd_t                    upd,
  output logic [$clog2(MAX_ORDERS)-1:0]          upd_idx,
  input  wire lobm_pkg::lobm_cand_t              cand,
  input  wire logic [$clog2(MAX_ORDERS)-1:0]     hit_idx,
  input  wire logic [$clog2(MAX_ORDERS)-1:0]     free_idx,
  input  wire logic [$clog2(MAX_ORDERS)-1:0]     best_idx
);

  localparam int CNT_W = $clog2(MAX_ORDERS + 1);
  localparam int PW    = lobm_pkg::PRICE_W;
  localparam int QW    = lobm_pkg::QTY_W;
  localparam int FW    = lobm_pkg::FILLS_W;

  lobm_pkg::lobm_state_t        state_r, state_nxt;
  lobm_pkg::lobm_status_t       status_r, status_nxt;
  logic                         cmd_r, cmd_nxt;
  logic [lobm_pkg::ID_W-1:0]    id_r, id_nxt;
  logic                         side_r, side_nxt;
  logic [PW-1:0]                price_r, price_nxt;
  logic [QW-1:0]                rem_r, rem_nxt;
  logic [QW-1:0]                filled_r, filled_nxt;
  logic [FW-1:0]                fills_r, fills_nxt;
  logic                         first_r, first_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [CNT_W-1:0]             live_r, live_nxt;
  logic [lobm_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [lobm_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [QW-1:0]                out_filled_r, out_filled_nxt;
  logic [QW-1:0]                out_resting_r, out_resting_nxt;
  logic [FW-1:0]                out_fills_r, out_fills_nxt;
  logic                         accept;
  logic                         scan_end;
  logic                         finish;
  logic                         out_load;
  logic                         full;
  logic [QW-1:0]                trade_q;

  assign in_ch.ready = (state_r == lobm_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign scan_end    = (state_r == lobm_pkg::S_SCAN) && (cnt_r == CNT_W'(MAX_ORDERS));
  assign out_load    = (state_r == lobm_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
  assign full        = (live_r == CNT_W'(MAX_ORDERS));
  assign trade_q     = (rem_r < cand.best_qty) ? rem_r : cand.best_qty;

  assign q.id    = id_r;
  assign q.side  = side_r;
  assign q.price = price_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lobm_pkg::S_IDLE: if (accept) state_nxt = lobm_pkg::S_SCAN;
      lobm_pkg::S_SCAN: if (finish) state_nxt = lobm_pkg::S_DONE;
      lobm_pkg::S_DONE: if (out_load) state_nxt = lobm_pkg::S_IDLE;
      default:          state_nxt = lobm_pkg::S_IDLE;
    endcase
  end

  // Datapath and cell writes
  always_comb begin
    cmd_nxt    = cmd_r;
    id_nxt     = id_r;
    side_nxt   = side_r;
    price_nxt  = price_r;
    rem_nxt    = rem_r;
    filled_nxt = filled_r;
    fills_nxt  = fills_r;
    first_nxt  = first_r;
    cnt_nxt    = cnt_r;
    live_nxt   = live_r;
    seq_nxt    = seq_r;
    status_nxt = status_r;
    finish     = 1'b0;
    upd        = '0;
    upd.op     = lobm_pkg::OP_NONE;
    upd_idx    = '0;
    case (state_r)
      lobm_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_ch.cmd;
          id_nxt     = in_ch.order_id;
          side_nxt   = in_ch.side;
          price_nxt  = (32'(in_ch.price_tick) >= lobm_pkg::PRICE_LEVELS) ?
                       PW'(lobm_pkg::PRICE_LEVELS - 1) : in_ch.price_tick;
          rem_nxt    = in_ch.quantity;
          filled_nxt = '0;
          fills_nxt  = '0;
          first_nxt  = 1'b1;
          cnt_nxt    = '0;
        end
      end
      lobm_pkg::S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (scan_end) begin
          cnt_nxt   = '0;
          first_nxt = 1'b0;
          if (cmd_r == lobm_pkg::CMD_CANCEL) begin
            // Cancel: drop the resting order if the id is known
            finish = 1'b1;
            if (cand.hit) begin
              upd.op     = lobm_pkg::OP_KILL;
              upd_idx    = hit_idx;
              live_nxt   = live_r - CNT_W'(1);
              status_nxt = lobm_pkg::STAT_CANCELLED;
            end else begin
              status_nxt = lobm_pkg::STAT_UNKNOWN;
            end
          end else if (first_r && rem_r == '0) begin
            finish     = 1'b1;
            status_nxt = lobm_pkg::STAT_ZERO;
          end else if (first_r && cand.hit) begin
            finish     = 1'b1;
            status_nxt = lobm_pkg::STAT_DUP;
          end else if (first_r && full) begin
            finish     = 1'b1;
            status_nxt = lobm_pkg::STAT_FULL;
          end else if (cand.best_found) begin
            // Trade against the best crossing order, then scan again unless the add is filled
            upd.op     = lobm_pkg::OP_TRADE;
            upd.qty    = trade_q;
            upd_idx    = best_idx;
            rem_nxt    = rem_r - trade_q;
            filled_nxt = filled_r + trade_q;
            fills_nxt  = fills_r + FW'(1);
            if (cand.best_qty == trade_q) begin
              live_nxt = live_r - CNT_W'(1);
            end
            if (rem_r == trade_q) begin
              finish     = 1'b1;
              status_nxt = lobm_pkg::STAT_FILLED;
            end
          end else begin
            // Nothing left to cross: rest the remainder
            finish     = 1'b1;
            upd.op     = lobm_pkg::OP_INSERT;
            upd.id     = id_r;
            upd.side   = side_r;
            upd.price  = price_r;
            upd.qty    = rem_r;
            upd.seq    = seq_r;
            upd_idx    = free_idx;
            live_nxt   = live_r + CNT_W'(1);
            seq_nxt    = seq_r + 64'd1;
            status_nxt = lobm_pkg::STAT_RESTED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result word register
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_filled_nxt  = out_filled_r;
    out_resting_nxt = out_resting_r;
    out_fills_nxt   = out_fills_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = status_r;
      out_filled_nxt  = filled_r;
      out_resting_nxt = (status_r == lobm_pkg::STAT_RESTED) ? rem_r : '0;
      out_fills_nxt   = fills_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lobm_pkg::S_IDLE;
      live_r      <= '0;
      seq_r       <= '0;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      seq_r       <= seq_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    id_r          <= id_nxt;
    side_r        <= side_nxt;
    price_r       <= price_nxt;
    rem_r         <= rem_nxt;
    filled_r      <= filled_nxt;
    fills_r       <= fills_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_filled_r  <= out_filled_nxt;
    out_resting_r <= out_resting_nxt;
    out_fills_r   <= out_fills_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.filled_quantity  = out_filled_r;
  assign out_ch.resting_quantity = out_resting_r;
  assign out_ch.fill_count       = out_fills_r;

  `LOBM_ASSERT_IMPL(a_insert_room, clk, rst_n, upd.op == lobm_pkg::OP_INSERT, live_r < CNT_W'(MAX_ORDERS), "insert into a full book")
  `LOBM_ASSERT_IMPL(a_trade_size, clk, rst_n, upd.op == lobm_pkg::OP_TRADE, upd.qty != '0 && upd.qty <= rem_r, "trade size out of range")
  `LOBM_ASSERT_NEXT(a_trade_rescan, clk, rst_n, upd.op == lobm_pkg::OP_TRADE && !finish, state_r == lobm_pkg::S_SCAN && cnt_r == '0, "partial fill did not start a new scan")

endmodule
`default_nettype wire
